>>> rtl/nbwu_pkg.sv
// ----------------------------------------------------------------------------
// nbwu_pkg
// Shared widths, codes and saturating Q8.16 arithmetic for the neuron
// backpropagation weight update core.
// ----------------------------------------------------------------------------
package nbwu_pkg;

   localparam int DATA_W             = 24;
   localparam int FRAC_W             = 16;
   localparam int KIND_W             = 2;
   localparam int LR_W               = 17;
   localparam int COUNT_W            = 9;
   localparam int LOAD_IDX_W         = 8;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = LR_W;
   localparam int DEFAULT_MAX_INPUTS = 256;

   localparam logic [LR_W-1:0]    LR_RESET    = 17'd6554;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

   localparam logic signed [DATA_W-1:0] V_MAX        = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] V_MIN        = -24'sh800000;
   localparam logic signed [DATA_W-1:0] Q_ONE        = 24'sh010000;
   localparam logic signed [DATA_W-1:0] HIDDEN_LIMIT = -24'sh010000;

   typedef enum logic [KIND_W-1:0] {
      KIND_BEGIN       = 2'd0,
      KIND_CONNECT     = 2'd1,
      KIND_LOAD_WEIGHT = 2'd2,
      KIND_LOAD_BIAS   = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEARNING_RATE = 1'd0,
      CSR_INPUT_COUNT   = 1'd1
   } csr_index_type;

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > V_MAX) begin
         r = V_MAX;
      end else if (v < V_MIN) begin
         r = V_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      return sat_wide(s);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      return sat_wide(s);
   endfunction

   // Full product, floor shift by the fraction width, then saturate.
   function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
      logic signed [2*DATA_W-1:0]        p;
      logic signed [2*DATA_W-FRAC_W-1:0] q;
      logic signed [DATA_W-1:0]          r;
      p = a * b;
      q = p[2*DATA_W-1:FRAC_W];
      if (q > V_MAX) begin
         r = V_MAX;
      end else if (q < V_MIN) begin
         r = V_MIN;
      end else begin
         r = q[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/nbwu_req_if.sv
// ----------------------------------------------------------------------------
// nbwu_req_if
// Request channel: pass, connection and load items with valid/ready.
// ----------------------------------------------------------------------------
interface nbwu_req_if;
   import nbwu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [DATA_W-1:0]  output_value;
   logic signed [DATA_W-1:0]  error_in;
   logic signed [DATA_W-1:0]  target_value;
   logic                      dropped_out;
   logic signed [DATA_W-1:0]  input_value;
   logic                      connected;
   logic [LOAD_IDX_W-1:0]     load_index;
   logic signed [DATA_W-1:0]  load_value;

   modport source (
      output valid, kind, output_value, error_in, target_value, dropped_out,
             input_value, connected, load_index, load_value,
      input  ready
   );

   modport sink (
      input  valid, kind, output_value, error_in, target_value, dropped_out,
             input_value, connected, load_index, load_value,
      output ready
   );
endinterface

>>> rtl/nbwu_rsp_if.sv
// ----------------------------------------------------------------------------
// nbwu_rsp_if
// Response channel: one result per in-pass connection, with valid/ready.
// ----------------------------------------------------------------------------
interface nbwu_rsp_if;
   import nbwu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  error_contribution;
   logic signed [DATA_W-1:0]  weight_min;
   logic signed [DATA_W-1:0]  weight_max;
   logic                      pass_done;

   modport source (
      output valid, error_contribution, weight_min, weight_max, pass_done,
      input  ready
   );

   modport sink (
      input  valid, error_contribution, weight_min, weight_max, pass_done,
      output ready
   );
endinterface

>>> rtl/neuron_backprop_weight_update_core.sv
// ----------------------------------------------------------------------------
// neuron_backprop_weight_update_core
// Backpropagation and momentum weight learning for one neuron in Q8.16.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Weights and their last changes sit
// together in one synchronous memory of MAX_INPUTS words, and one shared
// 24x24 multiplier evaluates every chained product, one product per cycle.
// A connected, non-dropped connection runs a memory read, four products (the
// last three chained) and a write back, and places its result in the output
// register before the next request can transfer. An unconnected or dropped
// connection passes only through the emit state; a load, a dropped begin pass
// or a surplus connection leaves the block idle; a live begin pass spends most
// of its time in a one-bit-per-cycle divider that forms the step size from the
// learning rate and the input count. The output register lets the next request
// transfer while a result waits; the block only stalls when a new result is
// ready and the previous one was not taken. Every memory entry must be written
// with its weight and a cleared last change by a load before any connection
// reads it (not enforced by the block), so no clearing pass is needed after
// reset. Configuration writes must only be issued while the block is idle.
module neuron_backprop_weight_update_core #(
   parameter int MAX_INPUTS = nbwu_pkg::DEFAULT_MAX_INPUTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [nbwu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nbwu_pkg::CSR_DATA_W-1:0]     csr_write_data,
   nbwu_req_if.sink                            req,
   nbwu_rsp_if.source                          rsp
);
   import nbwu_pkg::*;

   localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int CNT_W  = $clog2(MAX_INPUTS + 1);
   localparam int DCNT_W = $clog2(LR_W);
   localparam int DIV_W  = COUNT_W + 1;
   localparam int WORD_W = 2 * DATA_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_C_MUL0,
      ST_C_MUL1,
      ST_C_MUL2,
      ST_C_MUL3,
      ST_C_WR,
      ST_EMIT,
      ST_B_MUL0,
      ST_B_MUL1,
      ST_B_DIV,
      ST_B_MUL2,
      ST_B_MUL3,
      ST_B_BIAS
   } state_type;

   state_type                 state_ff;
   logic [LR_W-1:0]           lr_ff;
   logic [COUNT_W-1:0]        count_ff;

   logic signed [DATA_W-1:0]  bias_ff;
   logic signed [DATA_W-1:0]  bias_change_ff;
   logic signed [DATA_W-1:0]  step_ff;
   logic signed [DATA_W-1:0]  grad_ff;
   logic signed [DATA_W-1:0]  run_min_ff;
   logic signed [DATA_W-1:0]  run_max_ff;
   logic [CNT_W-1:0]          conn_idx_ff;
   logic                      dropped_ff;

   logic signed [DATA_W-1:0]  outv_ff;
   logic signed [DATA_W-1:0]  err_ff;
   logic signed [DATA_W-1:0]  x_ff;
   logic signed [DATA_W-1:0]  prod_ff;
   logic signed [DATA_W-1:0]  contrib_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic                      last_ff;

   logic [LR_W-1:0]           dq_ff;
   logic [COUNT_W-1:0]        rem_ff;
   logic [DCNT_W-1:0]         div_cnt_ff;

   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  rsp_contrib_ff;
   logic signed [DATA_W-1:0]  rsp_min_ff;
   logic signed [DATA_W-1:0]  rsp_max_ff;
   logic                      rsp_done_ff;

   logic [WORD_W-1:0]         mem [MAX_INPUTS];
   logic [WORD_W-1:0]         mem_rd_ff;

   logic signed [DATA_W-1:0]  rd_weight;
   logic signed [DATA_W-1:0]  rd_change;
   logic signed [DATA_W-1:0]  mul_a;
   logic signed [DATA_W-1:0]  mul_b;
   logic signed [DATA_W-1:0]  prod_in;
   logic signed [DATA_W-1:0]  weight_in;
   logic signed [DATA_W-1:0]  err_in;
   logic [CNT_W-1:0]          active_n;
   logic [CNT_W-1:0]          conn_next;
   logic                      accept;
   kind_type                  kind;
   logic                      conn_take;
   logic                      load_take;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_wa;
   logic [WORD_W-1:0]         mem_wd;
   logic [DIV_W-1:0]          divisor;
   logic [DIV_W-1:0]          div_trial;
   logic [DIV_W-1:0]          div_diff;
   logic                      qbit;
   logic [COUNT_W-1:0]        rem_in;
   logic                      rsp_free;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign kind      = kind_type'(req.kind);

   assign active_n  = (32'(count_ff) < 32'(MAX_INPUTS)) ? CNT_W'(count_ff)
                                                        : CNT_W'(MAX_INPUTS);
   assign conn_next = conn_idx_ff + CNT_W'(1);
   assign conn_take = accept && (kind == KIND_CONNECT) && (conn_idx_ff < active_n);
   assign load_take = accept && (kind == KIND_LOAD_WEIGHT)
                      && (32'(req.load_index) < 32'(MAX_INPUTS));

   assign rd_weight = mem_rd_ff[WORD_W-1:DATA_W];
   assign rd_change = mem_rd_ff[DATA_W-1:0];
   assign weight_in = sat_add(rd_weight, prod_ff);
   assign err_in    = (req.target_value > HIDDEN_LIMIT)
                      ? sat_sub(req.target_value, req.output_value) : req.error_in;

   // Restoring divider, one quotient bit per cycle.
   assign divisor   = {1'b0, count_ff} + DIV_W'(1);
   assign div_trial = {rem_ff, dq_ff[LR_W-1]};
   assign qbit      = (div_trial >= divisor);
   assign div_diff  = div_trial - divisor;
   assign rem_in    = qbit ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_C_MUL0: begin
            mul_a = grad_ff;
            mul_b = rd_weight;
         end
         ST_C_MUL1: begin
            mul_a = step_ff;
            mul_b = sat_add(rd_change, Q_ONE);
         end
         ST_C_MUL2: begin
            mul_a = prod_ff;
            mul_b = grad_ff;
         end
         ST_C_MUL3: begin
            mul_a = prod_ff;
            mul_b = x_ff;
         end
         ST_B_MUL0: begin
            mul_a = outv_ff;
            mul_b = sat_sub(Q_ONE, outv_ff);
         end
         ST_B_MUL1: begin
            mul_a = prod_ff;
            mul_b = err_ff;
         end
         ST_B_MUL2: begin
            mul_a = step_ff;
            mul_b = sat_add(bias_change_ff, Q_ONE);
         end
         default: begin
            mul_a = prod_ff;
            mul_b = grad_ff;
         end
      endcase
   end

   assign prod_in = qmul(mul_a, mul_b);

   assign mem_we = load_take || (state_ff == ST_C_WR);
   assign mem_wa = (state_ff == ST_C_WR) ? addr_ff : ADDR_W'(req.load_index);
   assign mem_wd = (state_ff == ST_C_WR) ? {weight_in, prod_ff}
                                         : {req.load_value, DATA_W'(0)};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (conn_take) begin
         mem_rd_ff <= mem[conn_idx_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lr_ff          <= LR_RESET;
         count_ff       <= COUNT_RESET;
         bias_ff        <= '0;
         bias_change_ff <= '0;
         step_ff        <= '0;
         grad_ff        <= '0;
         run_min_ff     <= V_MAX;
         run_max_ff     <= V_MIN;
         conn_idx_ff    <= '0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_LEARNING_RATE: lr_ff    <= csr_write_data[LR_W-1:0];
               CSR_INPUT_COUNT:   count_ff <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end

         // In the emit state the valid flag is set below instead.
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (kind)
                     KIND_BEGIN: begin
                        conn_idx_ff <= '0;
                        dropped_ff  <= req.dropped_out;
                        outv_ff     <= req.output_value;
                        err_ff      <= err_in;
                        if (!req.dropped_out) begin
                           state_ff <= ST_B_MUL0;
                        end
                     end
                     KIND_CONNECT: begin
                        if (conn_take) begin
                           conn_idx_ff <= conn_next;
                           addr_ff     <= conn_idx_ff[ADDR_W-1:0];
                           last_ff     <= (conn_next == active_n);
                           x_ff        <= req.input_value;
                           if (!dropped_ff && req.connected) begin
                              state_ff <= ST_C_MUL0;
                           end else begin
                              contrib_ff <= '0;
                              state_ff   <= ST_EMIT;
                           end
                        end
                     end
                     KIND_LOAD_BIAS: begin
                        bias_ff        <= req.load_value;
                        bias_change_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_C_MUL0: begin
               contrib_ff <= prod_in;
               state_ff   <= ST_C_MUL1;
            end
            ST_C_MUL1: begin
               prod_ff  <= prod_in;
               state_ff <= ST_C_MUL2;
            end
            ST_C_MUL2: begin
               prod_ff  <= prod_in;
               state_ff <= ST_C_MUL3;
            end
            ST_C_MUL3: begin
               prod_ff  <= prod_in;
               state_ff <= ST_C_WR;
            end
            ST_C_WR: begin
               if (weight_in < run_min_ff) begin
                  run_min_ff <= weight_in;
               end
               if (weight_in > run_max_ff) begin
                  run_max_ff <= weight_in;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_contrib_ff <= contrib_ff;
                  rsp_min_ff     <= run_min_ff;
                  rsp_max_ff     <= run_max_ff;
                  rsp_done_ff    <= last_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            ST_B_MUL0: begin
               prod_ff    <= prod_in;
               dq_ff      <= lr_ff;
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_B_MUL1;
            end
            ST_B_MUL1: begin
               grad_ff  <= prod_in;
               state_ff <= ST_B_DIV;
            end
            ST_B_DIV: begin
               rem_ff     <= rem_in;
               dq_ff      <= {dq_ff[LR_W-2:0], qbit};
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(LR_W - 1)) begin
                  step_ff  <= DATA_W'({dq_ff[LR_W-2:0], qbit});
                  state_ff <= ST_B_MUL2;
               end
            end
            ST_B_MUL2: begin
               prod_ff  <= prod_in;
               state_ff <= ST_B_MUL3;
            end
            ST_B_MUL3: begin
               bias_change_ff <= prod_in;
               state_ff       <= ST_B_BIAS;
            end
            ST_B_BIAS: begin
               bias_ff    <= sat_add(bias_ff, bias_change_ff);
               run_min_ff <= V_MAX;
               run_max_ff <= V_MIN;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.error_contribution = rsp_contrib_ff;
   assign rsp.weight_min         = rsp_min_ff;
   assign rsp.weight_max         = rsp_max_ff;
   assign rsp.pass_done          = rsp_done_ff;

endmodule

>>> rtl/nbwu_checker.sv
// ----------------------------------------------------------------------------
// nbwu_checker
// Port-level checks for the neuron backpropagation weight update core.
// ----------------------------------------------------------------------------
module nbwu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [nbwu_pkg::KIND_W-1:0]          req_kind,
   input logic                                 req_dropped_out,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [nbwu_pkg::DATA_W-1:0]   rsp_error_contribution,
   input logic signed [nbwu_pkg::DATA_W-1:0]   rsp_weight_min,
   input logic signed [nbwu_pkg::DATA_W-1:0]   rsp_weight_max,
   input logic                                 rsp_pass_done
);
   import nbwu_pkg::*;

   // No result may be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_contribution)
         && $stable(rsp_weight_min) && $stable(rsp_weight_max) && $stable(rsp_pass_done))
      else $error("stalled response changed");

   // Either no weight was updated yet, or the minimum does not exceed the maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight_min <= rsp_weight_max)
         || (rsp_weight_min == V_MAX && rsp_weight_max == V_MIN))
      else $error("weight range inconsistent");

   // A live begin pass keeps the request side busy while the gradient is formed.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_BEGIN && !req_dropped_out |=> !req_ready)
      else $error("request taken during begin pass");

endmodule

bind neuron_backprop_weight_update_core nbwu_checker u_nbwu_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req.valid),
   .req_ready              (req.ready),
   .req_kind               (req.kind),
   .req_dropped_out        (req.dropped_out),
   .rsp_valid              (rsp.valid),
   .rsp_ready              (rsp.ready),
   .rsp_error_contribution (rsp.error_contribution),
   .rsp_weight_min         (rsp.weight_min),
   .rsp_weight_max         (rsp.weight_max),
   .rsp_pass_done          (rsp.pass_done)
);

>>> tb/neuron_backprop_weight_update_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neuron_backprop_weight_update_core_tb
// Self-checking bench for the weight update core. A behavioral mirror of the
// Q8.16 gradient, momentum and weight arithmetic predicts every connection
// result; directed passes cover the corner cases and random training passes
// with random idling on both channels cover the rest.
// ----------------------------------------------------------------------------
module neuron_backprop_weight_update_core_tb;
   import nbwu_pkg::*;

   localparam int          SLOTS         = DEFAULT_MAX_INPUTS;
   localparam int          SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   typedef struct {
      kind_type                 kind;
      logic signed [DATA_W-1:0] output_value;
      logic signed [DATA_W-1:0] error_in;
      logic signed [DATA_W-1:0] target_value;
      logic                     dropped_out;
      logic signed [DATA_W-1:0] input_value;
      logic                     connected;
      logic [LOAD_IDX_W-1:0]    load_index;
      logic signed [DATA_W-1:0] load_value;
   } learn_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] contribution;
      logic signed [DATA_W-1:0] weight_min;
      logic signed [DATA_W-1:0] weight_max;
      logic                     pass_done;
   } contribution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   nbwu_req_if req_bus ();
   nbwu_rsp_if rsp_bus ();

   neuron_backprop_weight_update_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_bus.sink),
      .rsp              (rsp_bus.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the neuron's learning state and configuration.
   logic signed [DATA_W-1:0] weight_mirror [SLOTS] = '{default: '0};
   logic signed [DATA_W-1:0] change_mirror [SLOTS] = '{default: '0};
   logic signed [DATA_W-1:0] bias_mirror        = '0;
   logic signed [DATA_W-1:0] bias_change_mirror = '0;
   logic signed [DATA_W-1:0] rate_step          = '0;
   logic signed [DATA_W-1:0] pass_grad          = '0;
   logic signed [DATA_W-1:0] min_seen           = V_MAX;
   logic signed [DATA_W-1:0] max_seen           = V_MIN;
   int unsigned              conn_position      = 0;
   bit                       pass_skipped       = 1'b0;
   int unsigned              rate_cfg           = 32'(LR_RESET);
   int unsigned              count_cfg          = 32'(COUNT_RESET);

   contribution_type pending_contributions[$];
   int unsigned   failures      = 0;
   int unsigned   useful_items  = 0;
   int unsigned   cycle_count   = 0;
   int unsigned   tx_gap_max    = 0;
   int unsigned   rx_gap_max    = 0;
   int unsigned   rsp_hold_cycles = 0;
   int unsigned   phase_number  = 0;

   function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
      logic signed [DATA_W-1:0] r;
      if (v > longint'(V_MAX)) begin
         r = V_MAX;
      end else if (v < longint'(V_MIN)) begin
         r = V_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // The arithmetic shift of the full product rounds toward minus infinity.
   function automatic logic signed [DATA_W-1:0] fixed_mul(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp_q(p >>> FRAC_W);
   endfunction

   function automatic logic signed [DATA_W-1:0] momentum_delta(
         input logic signed [DATA_W-1:0] last);
      return fixed_mul(fixed_mul(rate_step, clamp_q(longint'(last) + longint'(Q_ONE))),
                       pass_grad);
   endfunction

   function automatic int unsigned active_inputs();
      return (count_cfg < SLOTS) ? count_cfg : SLOTS;
   endfunction

   // Updates the mirror for one accepted item and queues the result it causes.
   // Returns 0 for a connection beyond the end of the pass, which is ignored.
   function automatic bit predict_learning_step(input learn_req_type it);
      logic signed [DATA_W-1:0] err;
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] delta;
      contribution_type         res;
      bit                       took = 1'b1;
      case (it.kind)
         KIND_BEGIN: begin
            conn_position = 0;
            pass_skipped  = it.dropped_out;
            if (!it.dropped_out) begin
               err = it.error_in;
               if (it.target_value > -Q_ONE) begin
                  err = clamp_q(longint'(it.target_value) - longint'(it.output_value));
               end
               pass_grad = fixed_mul(fixed_mul(it.output_value,
                              clamp_q(longint'(Q_ONE) - longint'(it.output_value))), err);
               rate_step = clamp_q(longint'(rate_cfg / (1 + count_cfg)));
               bias_change_mirror = momentum_delta(bias_change_mirror);
               bias_mirror = clamp_q(longint'(bias_mirror) + longint'(bias_change_mirror));
               min_seen = V_MAX;
               max_seen = V_MIN;
            end
         end
         KIND_LOAD_WEIGHT: begin
            weight_mirror[it.load_index] = it.load_value;
            change_mirror[it.load_index] = '0;
         end
         KIND_LOAD_BIAS: begin
            bias_mirror        = it.load_value;
            bias_change_mirror = '0;
         end
         default: begin
            if (conn_position >= active_inputs()) begin
               took = 1'b0;
            end else begin
               res.contribution = '0;
               if (!pass_skipped && it.connected) begin
                  w = weight_mirror[conn_position];
                  res.contribution = fixed_mul(pass_grad, w);
                  delta = fixed_mul(momentum_delta(change_mirror[conn_position]),
                                    it.input_value);
                  change_mirror[conn_position] = delta;
                  w = clamp_q(longint'(w) + longint'(delta));
                  weight_mirror[conn_position] = w;
                  if (w < min_seen) min_seen = w;
                  if (w > max_seen) max_seen = w;
               end
               conn_position++;
               res.weight_min = min_seen;
               res.weight_max = max_seen;
               res.pass_done  = (conn_position == active_inputs());
               pending_contributions.push_back(res);
            end
         end
      endcase
      return took;
   endfunction

   // Mostly values near the useful range, with extremes and full-width noise.
   function automatic logic signed [DATA_W-1:0] draw_fixed();
      logic signed [DATA_W-1:0] r;
      case ($urandom_range(0, 9))
         0: r = V_MAX;
         1: r = V_MIN;
         2: r = '0;
         3, 4: r = DATA_W'($urandom);
         default: r = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
      endcase
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] draw_target();
      logic signed [DATA_W-1:0] r;
      int                       v;
      case ($urandom_range(0, 5))
         0: r = -Q_ONE;
         1: r = -Q_ONE + DATA_W'(1);
         2, 3: begin
            v = -65536 - int'($urandom_range(0, 8323072));
            r = v[DATA_W-1:0];
         end
         default: r = draw_fixed();
      endcase
      return r;
   endfunction

   function automatic learn_req_type draw_request(input kind_type k);
      learn_req_type it;
      it.kind         = k;
      it.output_value = draw_fixed();
      it.error_in     = draw_fixed();
      it.target_value = draw_target();
      it.dropped_out  = ($urandom_range(0, 9) == 0);
      it.input_value  = draw_fixed();
      it.connected    = ($urandom_range(0, 6) != 0);
      it.load_index   = LOAD_IDX_W'($urandom_range(0, 255));
      it.load_value   = draw_fixed();
      return it;
   endfunction

   task automatic send_item(input learn_req_type it);
      int unsigned gap;
      gap = $urandom_range(0, tx_gap_max);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind         <= it.kind;
      req_bus.output_value <= it.output_value;
      req_bus.error_in     <= it.error_in;
      req_bus.target_value <= it.target_value;
      req_bus.dropped_out  <= it.dropped_out;
      req_bus.input_value  <= it.input_value;
      req_bus.connected    <= it.connected;
      req_bus.load_index   <= it.load_index;
      req_bus.load_value   <= it.load_value;
      req_bus.valid        <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (predict_learning_step(it)) useful_items++;
   endtask

   task automatic send_connection(input logic signed [DATA_W-1:0] value, input bit link);
      learn_req_type it;
      it = draw_request(KIND_CONNECT);
      it.input_value = value;
      it.connected   = link;
      send_item(it);
   endtask

   task automatic send_begin(input logic signed [DATA_W-1:0] out_v,
                             input logic signed [DATA_W-1:0] err_v,
                             input logic signed [DATA_W-1:0] target_v,
                             input bit skip);
      learn_req_type it;
      it = draw_request(KIND_BEGIN);
      it.output_value = out_v;
      it.error_in     = err_v;
      it.target_value = target_v;
      it.dropped_out  = skip;
      send_item(it);
   endtask

   task automatic send_load(input kind_type k, input logic [LOAD_IDX_W-1:0] slot,
                            input logic signed [DATA_W-1:0] value);
      learn_req_type it;
      it = draw_request(k);
      it.load_index = slot;
      it.load_value = value;
      send_item(it);
   endtask

   // A begin pass produces no result, so the block may still be busy after the
   // last result; the settle time covers its longest item.
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_contributions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int unsigned rate, input int unsigned count);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LEARNING_RATE;
      csr_write_data   <= CSR_DATA_W'(rate);
      @(negedge clock);
      csr_index        <= CSR_INPUT_COUNT;
      csr_write_data   <= CSR_DATA_W'(count);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      rate_cfg  = rate & 32'h1FFFF;
      count_cfg = count & 32'h1FF;
   endtask

   // Every slot gets a weight before any connection can read one.
   task automatic preload_weights();
      for (int slot = 0; slot < SLOTS; slot++) begin
         send_load(KIND_LOAD_WEIGHT, LOAD_IDX_W'(slot), draw_fixed());
      end
   endtask

   task automatic test_reset_state();
      send_connection(draw_fixed(), 1'b1);
      send_connection(draw_fixed(), 1'b1);
   endtask

   task automatic test_output_unit();
      configure(65536, 3);
      send_begin(24'sh008000, draw_fixed(), Q_ONE, 1'b0);
      send_connection(V_MAX, 1'b1);
      send_connection(draw_fixed(), 1'b0);
      send_connection(V_MIN, 1'b1);
      // Target just above minus one still counts as an output unit.
      send_begin(V_MIN, V_MAX, -Q_ONE + DATA_W'(1), 1'b0);
      send_connection('0, 1'b1);
      send_connection(24'sh00C000, 1'b1);
      send_connection(V_MAX, 1'b1);
   endtask

   task automatic test_hidden_unit();
      send_begin(V_MAX, V_MIN, -Q_ONE, 1'b0);
      send_connection(V_MIN, 1'b1);
      send_connection(V_MAX, 1'b1);
      send_connection('0, 1'b1);
   endtask

   task automatic test_dropped_pass();
      send_begin(draw_fixed(), draw_fixed(), draw_target(), 1'b1);
      send_connection(V_MAX, 1'b1);
      send_connection(draw_fixed(), 1'b1);
      send_connection(V_MIN, 1'b1);
   endtask

   task automatic test_loads_mid_pass();
      send_begin(24'sh00C000, draw_fixed(), 24'sh004000, 1'b0);
      send_connection(draw_fixed(), 1'b1);
      send_load(KIND_LOAD_WEIGHT, 8'd1, V_MAX);
      send_load(KIND_LOAD_BIAS, LOAD_IDX_W'($urandom_range(0, 255)), V_MIN);
      send_connection(draw_fixed(), 1'b1);
      send_load(KIND_LOAD_WEIGHT, 8'd255, V_MIN);
      send_connection(draw_fixed(), 1'b1);
   endtask

   task automatic test_zero_count();
      configure(0, 0);
      send_begin(draw_fixed(), draw_fixed(), draw_target(), 1'b0);
      send_connection(draw_fixed(), 1'b1);
   endtask

   task automatic run_phase(input int unsigned rate, input int unsigned count,
                            input int unsigned budget);
      int unsigned first;
      int unsigned conns;
      configure(rate, count);
      phase_number++;
      tx_gap_max = (phase_number % 4 < 2) ? 19 : 0;
      rx_gap_max = (phase_number % 2 == 0) ? 19 : 0;
      first = useful_items;
      while (useful_items - first < budget) begin
         if ($urandom_range(0, 4) != 0) begin
            send_item(draw_request(KIND_BEGIN));
            conns = active_inputs();
            // Now and then a pass is cut short by the next begin.
            if ($urandom_range(0, 9) == 0) conns = $urandom_range(0, conns);
            for (int k = 0; k < conns; k++) begin
               if ($urandom_range(0, 24) == 0) begin
                  send_item(draw_request(kind_type'($urandom_range(2, 3))));
               end
               send_item(draw_request(KIND_CONNECT));
            end
            if ($urandom_range(0, 7) == 0) send_item(draw_request(KIND_CONNECT));
         end else begin
            send_item(draw_request(kind_type'($urandom_range(0, 3))));
         end
      end
   endtask

   task automatic test_random_training();
      run_phase(65536, 1, 100);
      run_phase(0, 5, 100);
      run_phase(LR_RESET, 2, 100);
      repeat (5) run_phase($urandom_range(0, 65536), $urandom_range(1, 12), 80);
      run_phase(40000, 256, 200);
      run_phase(20000, 300, 100);
      run_phase(65536, 0, 30);
   endtask

   // The receiver stalls for a long stretch while a full pass is offered
   // back to back, so the block has to hold off its input.
   task automatic test_backpressure();
      configure($urandom_range(1000, 65536), 48);
      tx_gap_max = 0;
      rx_gap_max = 0;
      rsp_hold_cycles = 300;
      send_begin(draw_fixed(), draw_fixed(), draw_target(), 1'b0);
      repeat (48) send_connection(draw_fixed(), 1'b1);
      drain_block();
   endtask

   task automatic compare_field(input string what, input logic signed [DATA_W-1:0] want,
                                input logic signed [DATA_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      contribution_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_contributions.size() == 0) begin
            failures++;
            $display("%0t: unexpected result transfer, expected none, actual %0d",
                     $realtime, rsp_bus.error_contribution);
         end else begin
            want = pending_contributions.pop_front();
            compare_field("error_contribution", want.contribution,
                          rsp_bus.error_contribution);
            compare_field("weight_min", want.weight_min, rsp_bus.weight_min);
            compare_field("weight_max", want.weight_max, rsp_bus.weight_max);
            compare_field("pass_done", DATA_W'(want.pass_done),
                          DATA_W'(rsp_bus.pass_done));
         end
      end
   end

   initial begin
      int unsigned wait_cycles;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         wait_cycles = $urandom_range(0, rx_gap_max);
         if (wait_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_BEGIN;
      req_bus.output_value = '0;
      req_bus.error_in     = '0;
      req_bus.target_value = '0;
      req_bus.dropped_out  = 1'b0;
      req_bus.input_value  = '0;
      req_bus.connected    = 1'b0;
      req_bus.load_index   = '0;
      req_bus.load_value   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      preload_weights();
      test_reset_state();
      test_output_unit();
      test_hidden_unit();
      test_dropped_pass();
      test_loads_mid_pass();
      test_zero_count();
      test_backpressure();
      test_random_training();
      drain_block();

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
